### rtl/core/sts_pkg.sv
// Package for the sorted key table: opcodes, status codes, controller states
// and the structs that pass between the controller and the compare-and-shift cells.
// No dependencies.
package sts_pkg;

   localparam int OP_W     = 2;
   localparam int POS_W    = 6;
   localparam int STATUS_W = 2;

   typedef enum logic [OP_W-1:0] {
      OP_INSERT   = 2'd0,
      OP_REMOVE   = 2'd1,
      OP_CONTAINS = 2'd2,
      OP_GET      = 2'd3
   } op_type;

   typedef enum logic [STATUS_W-1:0] {
      ST_OK        = 2'd0,
      ST_NOT_FOUND = 2'd1,
      ST_FULL      = 2'd2,
      ST_RANGE     = 2'd3
   } status_type;

   typedef enum logic {
      S_IDLE   = 1'b0,
      S_UPDATE = 1'b1
   } state_type;

   // Commands broadcast to every cell.
   typedef struct packed {
      logic compare;
      logic insert;
      logic remove;
   } cell_cmd_type;

   // Flags that each cell reports back.
   typedef struct packed {
      logic lt;
      logic first;
      logic hit;
      logic sel;
   } cell_flags_type;

endpackage

### rtl/core/sts_cell.sv
// One compare-and-shift cell of the sorted key table.
// Holds one key, compares it with the incoming key and shifts toward a neighbor.
// Depends on sts_pkg.
module sts_cell #(
   parameter  int CAPACITY  = 64,
   parameter  int KEY_WIDTH = 32,
   parameter  int IDX       = 0,
   localparam int CNT_W     = $clog2(CAPACITY + 1),
   localparam int IW        = (CNT_W > sts_pkg::POS_W) ? CNT_W : sts_pkg::POS_W
) (
   input  logic                        clock,
   input  sts_pkg::cell_cmd_type       cmd,
   input  logic [KEY_WIDTH-1:0]        cmp_key,
   input  logic [KEY_WIDTH-1:0]        ins_key,
   input  logic [CNT_W-1:0]            count,
   input  logic [sts_pkg::POS_W-1:0]   position,
   input  logic [KEY_WIDTH-1:0]        left_key,
   input  logic [KEY_WIDTH-1:0]        right_key,
   input  logic                        left_lt,
   output logic [KEY_WIDTH-1:0]        key,
   output sts_pkg::cell_flags_type     flags
);

   logic [KEY_WIDTH-1:0] key_ff;
   logic [KEY_WIDTH-1:0] key_in;
   logic                 lt_ff;
   logic                 eq_ff;
   logic                 sel_ff;
   logic                 occupied;
   logic                 first;

   assign occupied = CNT_W'(IDX) < count;
   assign first    = !lt_ff && left_lt;

   always_comb begin
      key_in = key_ff;
      if (cmd.insert && !lt_ff) begin
         key_in = first ? ins_key : left_key;
      end else if (cmd.remove && !lt_ff) begin
         key_in = right_key;
      end
   end

   always_ff @(posedge clock) begin
      key_ff <= key_in;
      if (cmd.compare) begin
         lt_ff  <= occupied && (key_ff < cmp_key);
         eq_ff  <= occupied && (key_ff == cmp_key);
         sel_ff <= occupied && (IW'(IDX) == IW'(position));
      end
   end

   assign key         = key_ff;
   assign flags.lt    = lt_ff;
   assign flags.first = first;
   assign flags.hit   = first && eq_ff;
   assign flags.sel   = sel_ff;

endmodule

### rtl/core/sorted_table_binary_search.sv
// Top level of the sorted key table: controller, result register and the cell chain.
// Depends on sts_pkg and sts_cell.
//
//   channel   direction  handshake            payload
//   req       in         req_valid/req_stall  req_opcode, req_key, req_position
//   rsp       out        rsp_valid/rsp_stall  rsp_status, rsp_where, rsp_key_read,
//                                             rsp_entry_count
//
// For each item, all cells compare against the key at the accepting edge, and the
// update step then shifts the cell chain and loads the result register.
// The update waits while the result register holds a result that is stalled.
// Reset clears the entry count and the control state; the stored keys are not cleared.
// One result item is produced for every accepted item, in order.
module sorted_table_binary_search #(
   parameter  int CAPACITY  = 64,
   parameter  int KEY_WIDTH = 32,
   localparam int CNT_W     = $clog2(CAPACITY + 1)
) (
   input  logic                            clock,
   input  logic                            reset,
   input  logic                            req_valid,
   output logic                            req_stall,
   input  logic [sts_pkg::OP_W-1:0]        req_opcode,
   input  logic [KEY_WIDTH-1:0]            req_key,
   input  logic [sts_pkg::POS_W-1:0]       req_position,
   output logic                            rsp_valid,
   input  logic                            rsp_stall,
   output logic [sts_pkg::STATUS_W-1:0]    rsp_status,
   output logic [CNT_W-1:0]                rsp_where,
   output logic [KEY_WIDTH-1:0]            rsp_key_read,
   output logic [CNT_W-1:0]                rsp_entry_count
);

   sts_pkg::state_type      state_ff;
   sts_pkg::state_type      state_in;
   sts_pkg::op_type         op_ff;
   logic [KEY_WIDTH-1:0]    key_ff;
   logic [sts_pkg::POS_W-1:0] pos_ff;
   logic [CNT_W-1:0]        count_ff;
   logic [CNT_W-1:0]        count_in;

   logic                    rsp_valid_ff;
   logic                    rsp_valid_in;
   sts_pkg::status_type     rsp_status_ff;
   sts_pkg::status_type     rsp_status_in;
   logic [CNT_W-1:0]        rsp_where_ff;
   logic [CNT_W-1:0]        rsp_where_in;
   logic [KEY_WIDTH-1:0]    rsp_key_read_ff;
   logic [KEY_WIDTH-1:0]    rsp_key_read_in;

   logic                    accept;
   logic                    finish;
   logic                    full;
   logic                    found;
   logic                    in_range;
   logic [CNT_W-1:0]        lower;
   logic [KEY_WIDTH-1:0]    read_key;
   logic [CAPACITY-1:0]     hit_vec;
   logic [CAPACITY-1:0]     first_vec;

   sts_pkg::cell_cmd_type   cmd;
   logic [KEY_WIDTH-1:0]    cell_key   [CAPACITY];
   sts_pkg::cell_flags_type cell_flags [CAPACITY];

   assign accept = req_valid && !req_stall;
   assign full   = count_ff == CNT_W'(CAPACITY);

   for (genvar i = 0; i < CAPACITY; i++) begin : g_cell
      logic [KEY_WIDTH-1:0] left_key;
      logic [KEY_WIDTH-1:0] right_key;
      logic                 left_lt;

      if (i == 0) begin : g_head
         assign left_key = cell_key[i];
         assign left_lt  = 1'b1;
      end else begin : g_body
         assign left_key = cell_key[i-1];
         assign left_lt  = cell_flags[i-1].lt;
      end
      if (i == CAPACITY - 1) begin : g_tail
         assign right_key = cell_key[i];
      end else begin : g_inner
         assign right_key = cell_key[i+1];
      end

      sts_cell #(
         .CAPACITY  (CAPACITY),
         .KEY_WIDTH (KEY_WIDTH),
         .IDX       (i)
      ) u_cell (
         .clock     (clock),
         .cmd       (cmd),
         .cmp_key   (req_key),
         .ins_key   (key_ff),
         .count     (count_ff),
         .position  (req_position),
         .left_key  (left_key),
         .right_key (right_key),
         .left_lt   (left_lt),
         .key       (cell_key[i]),
         .flags     (cell_flags[i])
      );
   end

   always_comb begin
      found    = 1'b0;
      in_range = 1'b0;
      lower    = '0;
      read_key = '0;
      for (int i = 0; i < CAPACITY; i++) begin
         hit_vec[i]   = cell_flags[i].hit;
         first_vec[i] = cell_flags[i].first;
         found        = found | cell_flags[i].hit;
         in_range     = in_range | cell_flags[i].sel;
         lower        = lower | (cell_flags[i].first ? CNT_W'(i) : '0);
         read_key     = read_key | (cell_flags[i].sel ? cell_key[i] : '0);
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= sts_pkg::S_IDLE;
         count_ff     <= '0;
         rsp_valid_ff <= 1'b0;
      end else begin
         state_ff     <= state_in;
         count_ff     <= count_in;
         rsp_valid_ff <= rsp_valid_in;
      end
   end

   always_ff @(posedge clock) begin
      if (accept) begin
         op_ff  <= sts_pkg::op_type'(req_opcode);
         key_ff <= req_key;
         pos_ff <= req_position;
      end
      if (finish) begin
         rsp_status_ff   <= rsp_status_in;
         rsp_where_ff    <= rsp_where_in;
         rsp_key_read_ff <= rsp_key_read_in;
      end
   end

   always_comb begin
      state_in        = state_ff;
      count_in        = count_ff;
      req_stall       = 1'b0;
      finish          = 1'b0;
      cmd             = '0;
      rsp_valid_in    = rsp_valid_ff && rsp_stall;
      rsp_status_in   = sts_pkg::ST_OK;
      rsp_where_in    = '0;
      rsp_key_read_in = '0;

      case (op_ff)
         sts_pkg::OP_INSERT: begin
            if (full) begin
               rsp_status_in = sts_pkg::ST_FULL;
            end else begin
               rsp_where_in = lower;
            end
         end
         sts_pkg::OP_REMOVE, sts_pkg::OP_CONTAINS: begin
            if (found) begin
               rsp_where_in = lower;
            end else begin
               rsp_status_in = sts_pkg::ST_NOT_FOUND;
            end
         end
         default: begin
            if (in_range) begin
               rsp_where_in    = CNT_W'(pos_ff);
               rsp_key_read_in = read_key;
            end else begin
               rsp_status_in = sts_pkg::ST_RANGE;
            end
         end
      endcase

      case (state_ff)
         sts_pkg::S_IDLE: begin
            cmd.compare = req_valid;
            if (req_valid) begin
               state_in = sts_pkg::S_UPDATE;
            end
         end
         sts_pkg::S_UPDATE: begin
            req_stall = 1'b1;
            if (!rsp_valid_ff || !rsp_stall) begin
               finish       = 1'b1;
               rsp_valid_in = 1'b1;
               state_in     = sts_pkg::S_IDLE;
               if (op_ff == sts_pkg::OP_INSERT && !full) begin
                  cmd.insert = 1'b1;
                  count_in   = count_ff + CNT_W'(1);
               end else if (op_ff == sts_pkg::OP_REMOVE && found) begin
                  cmd.remove = 1'b1;
                  count_in   = count_ff - CNT_W'(1);
               end
            end
         end
         default: begin
            state_in = sts_pkg::S_IDLE;
         end
      endcase
   end

   // The entry count in a result always reflects the count after the update.
   logic [CNT_W-1:0] rsp_count_ff;

   always_ff @(posedge clock) begin
      if (finish) begin
         rsp_count_ff <= count_in;
      end
   end

   assign rsp_valid       = rsp_valid_ff;
   assign rsp_status      = rsp_status_ff;
   assign rsp_where       = rsp_where_ff;
   assign rsp_key_read    = rsp_key_read_ff;
   assign rsp_entry_count = rsp_count_ff;

`ifndef SYNTHESIS
   a_count_bound: assert property (@(posedge clock) disable iff (reset)
      count_ff <= CNT_W'(CAPACITY))
      else $error("entry count exceeds capacity");

   a_single_hit: assert property (@(posedge clock) disable iff (reset)
      state_ff == sts_pkg::S_UPDATE |-> $onehot0(hit_vec) && $onehot0(first_vec))
      else $error("more than one cell claims the lower bound");

   a_accept_update: assert property (@(posedge clock) disable iff (reset)
      accept |=> state_ff == sts_pkg::S_UPDATE)
      else $error("accepted item did not enter the update step");

   a_insert_count: assert property (@(posedge clock) disable iff (reset)
      cmd.insert |=> count_ff == $past(count_ff) + CNT_W'(1))
      else $error("insert did not raise the entry count");

   a_full_status: assert property (@(posedge clock) disable iff (reset)
      (rsp_valid_ff && rsp_status_ff == sts_pkg::ST_FULL)
         |-> rsp_count_ff == CNT_W'(CAPACITY))
      else $error("table full reported below capacity");
`endif

endmodule

### sim/sorted_table_binary_search_tb.sv
// Testbench for sorted_table_binary_search: directed and random table operations with
// random idling on both channels, checked against a behavioral model of the table.
// Depends on sts_pkg and the RTL of sorted_table_binary_search.
module sorted_table_binary_search_tb;

   localparam int CAP   = 64;
   localparam int KW    = 32;
   localparam int CNT_W = $clog2(CAP + 1);

   typedef struct {
      sts_pkg::status_type status;
      logic [CNT_W-1:0]    where;
      logic [KW-1:0]       key_read;
      logic [CNT_W-1:0]    entry_count;
   } table_result_type;

   class table_scoreboard_type;
      logic [KW-1:0]    keys [CAP];
      int               count;
      int               errors;
      table_result_type pending [$];

      function new();
         count  = 0;
         errors = 0;
      endfunction

      function int lower_bound(logic [KW-1:0] key);
         int lo;
         int hi;
         int mid;
         lo = 0;
         hi = count;
         while (lo < hi) begin
            mid = lo + (hi - lo) / 2;
            if (keys[mid] < key) begin
               lo = mid + 1;
            end else begin
               hi = mid;
            end
         end
         return lo;
      endfunction

      function void note_item(sts_pkg::op_type op, logic [KW-1:0] key,
                              logic [sts_pkg::POS_W-1:0] pos);
         table_result_type r;
         int               lb;
         r.status   = sts_pkg::ST_OK;
         r.where    = '0;
         r.key_read = '0;
         case (op)
            sts_pkg::OP_INSERT: begin
               if (count >= CAP) begin
                  r.status = sts_pkg::ST_FULL;
               end else begin
                  lb = lower_bound(key);
                  for (int i = count; i > lb; i--) keys[i] = keys[i-1];
                  keys[lb] = key;
                  count++;
                  r.where = CNT_W'(lb);
               end
            end
            sts_pkg::OP_REMOVE: begin
               lb = lower_bound(key);
               if (lb < count && keys[lb] == key) begin
                  for (int i = lb; i < count - 1; i++) keys[i] = keys[i+1];
                  count--;
                  r.where = CNT_W'(lb);
               end else begin
                  r.status = sts_pkg::ST_NOT_FOUND;
               end
            end
            sts_pkg::OP_CONTAINS: begin
               lb = lower_bound(key);
               if (lb < count && keys[lb] == key) begin
                  r.where = CNT_W'(lb);
               end else begin
                  r.status = sts_pkg::ST_NOT_FOUND;
               end
            end
            default: begin
               if (pos < count) begin
                  r.key_read = keys[pos];
                  r.where    = CNT_W'(pos);
               end else begin
                  r.status = sts_pkg::ST_RANGE;
               end
            end
         endcase
         r.entry_count = CNT_W'(count);
         pending.push_back(r);
      endfunction

      task report_mismatch(string field, logic [KW-1:0] got, logic [KW-1:0] want);
         errors++;
         $display("mismatch in %s: got %0h, expected %0h", field, got, want);
      endtask

      task check_result(logic [sts_pkg::STATUS_W-1:0] status, logic [CNT_W-1:0] where,
                        logic [KW-1:0] key_read, logic [CNT_W-1:0] entry_count);
         table_result_type e;
         if (pending.size() == 0) begin
            report_mismatch("result with no item pending", KW'(status), '0);
         end else begin
            e = pending.pop_front();
            if (status !== e.status) begin
               report_mismatch("status", KW'(status), KW'(e.status));
            end
            if (where !== e.where) report_mismatch("where", KW'(where), KW'(e.where));
            if (key_read !== e.key_read) report_mismatch("key_read", key_read, e.key_read);
            if (entry_count !== e.entry_count) begin
               report_mismatch("entry_count", KW'(entry_count), KW'(e.entry_count));
            end
         end
      endtask
   endclass

   logic                          clock        = 1'b0;
   logic                          reset        = 1'b1;
   logic                          req_valid    = 1'b0;
   logic                          req_stall;
   logic [sts_pkg::OP_W-1:0]      req_opcode   = sts_pkg::OP_INSERT;
   logic [KW-1:0]                 req_key      = '0;
   logic [sts_pkg::POS_W-1:0]     req_position = '0;
   logic                          rsp_valid;
   logic                          rsp_stall    = 1'b0;
   logic [sts_pkg::STATUS_W-1:0]  rsp_status;
   logic [CNT_W-1:0]              rsp_where;
   logic [KW-1:0]                 rsp_key_read;
   logic [CNT_W-1:0]              rsp_entry_count;

   table_scoreboard_type sb = new();
   bit                   idle_on = 1'b1;
   int                   stall_left = 0;
   int                   items_sent = 0;

   sorted_table_binary_search DUT (
      .clock           (clock),
      .reset           (reset),
      .req_valid       (req_valid),
      .req_stall       (req_stall),
      .req_opcode      (req_opcode),
      .req_key         (req_key),
      .req_position    (req_position),
      .rsp_valid       (rsp_valid),
      .rsp_stall       (rsp_stall),
      .rsp_status      (rsp_status),
      .rsp_where       (rsp_where),
      .rsp_key_read    (rsp_key_read),
      .rsp_entry_count (rsp_entry_count)
   );

   initial begin
      forever #5 clock = ~clock;
   end

   initial begin
      #5000000;
      $display("sorted_table_binary_search test failed");
      $finish;
   end

   always @(posedge clock) begin
      if (reset) begin
         rsp_stall <= 1'b0;
      end else begin
         if (rsp_valid && !rsp_stall) begin
            sb.check_result(rsp_status, rsp_where, rsp_key_read, rsp_entry_count);
            stall_left = idle_on ? $urandom_range(0, 5) : 0;
         end
         if (stall_left > 0) begin
            rsp_stall <= 1'b1;
            stall_left--;
         end else begin
            rsp_stall <= 1'b0;
         end
      end
   end

   task automatic send_item(sts_pkg::op_type op, logic [KW-1:0] key,
                            logic [sts_pkg::POS_W-1:0] pos);
      int gap;
      gap = idle_on ? $urandom_range(0, 5) : 0;
      if (gap > 0) begin
         req_valid <= 1'b0;
         repeat (gap) @(posedge clock);
      end
      req_valid    <= 1'b1;
      req_opcode   <= op;
      req_key      <= key;
      req_position <= pos;
      @(posedge clock);
      while (req_stall) @(posedge clock);
      sb.note_item(op, key, pos);
      items_sent++;
   endtask

   task automatic wait_for_results();
      req_valid <= 1'b0;
      while (sb.pending.size() != 0) @(posedge clock);
   endtask

   function automatic logic [KW-1:0] pick_key();
      int r;
      r = $urandom_range(0, 99);
      if (r < 40 && sb.count > 0) return sb.keys[$urandom_range(0, sb.count - 1)];
      if (r < 70) return KW'($urandom_range(0, 15));
      if (r < 85) return KW'($urandom());
      case ($urandom_range(0, 3))
         0: return '0;
         1: return '1;
         2: return (sb.count > 0) ?
                   KW'(sb.keys[$urandom_range(0, sb.count - 1)] + KW'(1)) : KW'(1);
         default: return (sb.count > 0) ?
                   KW'(sb.keys[$urandom_range(0, sb.count - 1)] - KW'(1)) : '0;
      endcase
   endfunction

   function automatic logic [sts_pkg::POS_W-1:0] pick_position();
      if ($urandom_range(0, 9) < 7) begin
         return (sb.count < CAP) ? sts_pkg::POS_W'($urandom_range(0, sb.count)) : '1;
      end
      return sts_pkg::POS_W'($urandom_range(0, 63));
   endfunction

   function automatic sts_pkg::op_type pick_op(int kind);
      int r;
      r = $urandom_range(0, 99);
      case (kind)
         0: return (r < 85) ? sts_pkg::OP_INSERT : (r < 90) ? sts_pkg::OP_REMOVE :
                   (r < 95) ? sts_pkg::OP_CONTAINS : sts_pkg::OP_GET;
         1: return (r < 15) ? sts_pkg::OP_INSERT : (r < 70) ? sts_pkg::OP_REMOVE :
                   (r < 85) ? sts_pkg::OP_CONTAINS : sts_pkg::OP_GET;
         default: return sts_pkg::op_type'($urandom_range(0, 3));
      endcase
   endfunction

   initial begin
      int kind;
      int len;
      repeat (3) @(posedge clock);
      reset <= 1'b0;

      send_item(sts_pkg::OP_CONTAINS, 32'd5, 6'd0);
      send_item(sts_pkg::OP_REMOVE, 32'd5, 6'd0);
      send_item(sts_pkg::OP_GET, 32'd0, 6'd0);
      send_item(sts_pkg::OP_INSERT, 32'hFFFF_FFFF, 6'd63);
      send_item(sts_pkg::OP_INSERT, 32'd0, 6'd0);
      send_item(sts_pkg::OP_INSERT, 32'd5, 6'd0);
      send_item(sts_pkg::OP_INSERT, 32'd5, 6'd0);
      send_item(sts_pkg::OP_INSERT, 32'h8000_0000, 6'd0);
      send_item(sts_pkg::OP_INSERT, 32'd5, 6'd0);
      send_item(sts_pkg::OP_CONTAINS, 32'd5, 6'd0);
      send_item(sts_pkg::OP_CONTAINS, 32'd6, 6'd0);
      send_item(sts_pkg::OP_CONTAINS, 32'hFFFF_FFFF, 6'd0);
      send_item(sts_pkg::OP_GET, 32'd0, 6'd0);
      send_item(sts_pkg::OP_GET, 32'd0, 6'd5);
      send_item(sts_pkg::OP_GET, 32'd0, 6'd6);
      send_item(sts_pkg::OP_GET, 32'hFFFF_FFFF, 6'd63);
      send_item(sts_pkg::OP_REMOVE, 32'd5, 6'd0);
      send_item(sts_pkg::OP_REMOVE, 32'd7, 6'd0);
      send_item(sts_pkg::OP_REMOVE, 32'hFFFF_FFFF, 6'd0);
      send_item(sts_pkg::OP_REMOVE, 32'd0, 6'd0);
      send_item(sts_pkg::OP_GET, 32'd0, 6'd0);
      wait_for_results();

      kind = 0;
      while (items_sent < 460) begin
         len = (kind == 0) ? 90 : $urandom_range(20, 80);
         idle_on = ($urandom_range(0, 3) != 0);
         repeat (len) send_item(pick_op(kind), pick_key(), pick_position());
         if ($urandom_range(0, 1) == 1) wait_for_results();
         kind = $urandom_range(0, 2);
      end

      wait_for_results();
      repeat (8) @(posedge clock);
      if (sb.errors == 0) begin
         $display("sorted_table_binary_search test passed");
      end else begin
         $display("sorted_table_binary_search test failed");
      end
      $finish;
   end

endmodule
